### design/sr_io_pkg.sv
// ============================================================================
// sr_io_pkg
// types and constants shared by the shift-register i/o refresh block
// ============================================================================
package sr_io_pkg;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_MASK  = 2'd2,
        CMD_START = 2'd3
    } cmd_t;

    localparam int PHASE_W = 6;
    typedef logic [PHASE_W-1:0] phase_t;

    // phase schedule landmarks
    localparam phase_t PH_IDLE      = 6'd0;
    localparam phase_t PH_LOAD_LAST = 6'd3;
    localparam phase_t PH_LOAD_CLK  = 6'd2;
    localparam phase_t PH_IN_FIRST  = 6'd4;
    localparam phase_t PH_IN_LAST   = 6'd19;
    localparam phase_t PH_COMPARE   = 6'd20;
    localparam phase_t PH_OUT_FIRST = 6'd21;
    localparam phase_t PH_OUT_LAST  = 6'd36;
    localparam phase_t PH_OUT_HOLD  = 6'd37;
    localparam phase_t PH_LATCH     = 6'd38;
    localparam phase_t PH_LAST      = 6'd39;

    typedef struct packed {
        cmd_t       cmd;
        logic       di;
        logic [7:0] out_byte;
        logic [7:0] out_mask;
        logic       bit_value;
    } req_t;

    typedef struct packed {
        logic       load_n;
        logic       in_clk;
        logic       out_clk;
        logic       out_data;
        logic       latch;
        logic [7:0] input_byte;
        logic       inputs_changed;
        logic       busy_res;
    } rsp_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] in_shift;
        logic [7:0] in_image;
        logic [7:0] out_image;
        logic [7:0] out_snap;
    } seq_state_t;

endpackage

### design/sr_io_step.sv
// ============================================================================
// sr_io_step
// one sequencer phase: applies the host command and executes the pin phase
// ============================================================================
module sr_io_step (
    input  sr_io_pkg::seq_state_t cur,
    input  sr_io_pkg::req_t       req,
    output sr_io_pkg::seq_state_t nxt,
    output sr_io_pkg::rsp_t       rsp
);
    import sr_io_pkg::*;

    logic [7:0] img;
    phase_t     p;
    phase_t     off_in;
    phase_t     off_out;
    logic [2:0] in_bit;
    logic [2:0] out_bit;

    always_comb
    begin
        // host write lands before the phase action
        unique case (req.cmd)
            CMD_WRITE: img = req.out_byte;
            CMD_MASK:  img = req.bit_value ? (cur.out_image | req.out_mask)
                                           : (cur.out_image & ~req.out_mask);
            default:   img = cur.out_image;
        endcase

        p = (cur.phase > PH_LAST) ? PH_IDLE : cur.phase;
        if (p == PH_IDLE && req.cmd == CMD_START)
        begin
            p = 6'd1;
        end

        off_in  = p - PH_IN_FIRST;
        off_out = p - PH_OUT_FIRST;
        in_bit  = off_in[3:1];
        out_bit = ~off_out[3:1];

        nxt           = cur;
        nxt.out_image = img;
        nxt.phase     = p;

        rsp                = '0;
        rsp.load_n         = 1'b1;

        if (p != PH_IDLE)
        begin
            rsp.busy_res = 1'b1;
            if (p <= PH_LOAD_LAST)
            begin
                rsp.load_n = 1'b0;
                rsp.in_clk = (p == PH_LOAD_CLK);
            end
            else if (p <= PH_IN_LAST)
            begin
                if (!off_in[0])
                begin
                    nxt.in_shift[in_bit] = ~req.di;
                end
                else
                begin
                    rsp.in_clk = 1'b1;
                end
            end
            else if (p == PH_COMPARE)
            begin
                rsp.inputs_changed = (cur.in_shift != cur.in_image);
                nxt.in_image       = cur.in_shift;
                nxt.out_snap       = img;
            end
            else if (p <= PH_OUT_LAST)
            begin
                rsp.out_data = cur.out_snap[out_bit];
                rsp.out_clk  = off_out[0];
            end
            else if (p == PH_OUT_HOLD)
            begin
                rsp.out_data = cur.out_snap[0];
            end
            else if (p == PH_LATCH)
            begin
                rsp.out_data = cur.out_snap[0];
                rsp.latch    = 1'b1;
            end
            nxt.phase = (p >= PH_LAST) ? PH_IDLE : p + 6'd1;
        end

        rsp.input_byte = nxt.in_image;
    end

endmodule

### design/shift_register_io_refresh_core.sv
// ============================================================================
// shift_register_io_refresh_core
// serial i/o expander sequencer: one request beat is one pin phase
// ============================================================================
// path: a request beat is accepted into the input register, and the phase
//   logic then writes its response beat into the response register
// throughput: one beat per cycle, set by the phase update of the sequencer
//   state; a stalled response holds the next beat in the input
//   register and then drops req_ready
// reset: rst_n asynchronous, active low; sequencer idle, all images zero,
//   both stages empty
module shift_register_io_refresh_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  sr_io_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output sr_io_pkg::rsp_t  rsp
);
    import sr_io_pkg::*;

    // input stage
    logic       s1_valid_reg;
    req_t       s1_req_reg;

    // sequencer state and response register
    seq_state_t st_reg;
    seq_state_t st_next;
    rsp_t       rsp_next;
    logic       rsp_valid_reg;
    rsp_t       rsp_reg;

    logic       rsp_free;
    logic       advance;

    // response register is free when empty or being drained this cycle
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    // the phase is executed as the beat moves from the input register out
    assign advance   = s1_valid_reg && rsp_free;
    assign req_ready = !s1_valid_reg || advance;

    sr_io_step u_step (
        .cur (st_reg),
        .req (s1_req_reg),
        .nxt (st_next),
        .rsp (rsp_next)
    );

    // control and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (rsp_free)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### design/sr_io_checker.sv
// ============================================================================
// sr_io_checker
// port-level checks on the response channel of the refresh sequencer
// ============================================================================
module sr_io_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input sr_io_pkg::rsp_t rsp
);
    import sr_io_pkg::*;

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // idle phases drive no pin activity
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.busy_res |-> rsp.load_n && !rsp.in_clk && !rsp.out_clk
            && !rsp.out_data && !rsp.latch && !rsp.inputs_changed)
        else $error("pin activity outside a refresh");

    // latch only pulses in the output part of a refresh
    a_latch_phase: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.latch |-> rsp.busy_res && rsp.load_n && !rsp.in_clk
            && !rsp.out_clk)
        else $error("latch pulse out of sequence");

    // change flag only in the compare phase, where both chains are quiet
    a_change_phase: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.inputs_changed |-> rsp.busy_res && rsp.load_n
            && !rsp.in_clk && !rsp.out_clk && !rsp.latch && !rsp.out_data)
        else $error("change flag out of sequence");

endmodule

bind shift_register_io_refresh_core sr_io_checker u_sr_io_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

### sim/tb_top.sv
// ============================================================================
// tb_top
// testbench for shift_register_io_refresh_core: request beats carry one pin
// phase each; a built-in phase predictor forms the expected response beat for
// every accepted request, and a checker compares responses in order
// ============================================================================
module tb_top;
    import sr_io_pkg::*;

    // watchdog: cycles with no beat on either channel before the run is abandoned
    localparam int STALL_LIMIT   = 4000;
    // settle time after the last expected response (two-stage pipe, plus margin)
    localparam int DRAIN_CYCLES  = 20;
    // long sink hold-off used to fill the block and stall its request side
    localparam int HOLD_OFF_LEN  = 300;
    localparam int MAX_REPORTS   = 10;
    localparam phase_t PH_LOAD_FIRST = PH_IDLE + phase_t'(1);

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_ready;
    req_t  req_beat = '0;
    logic  rsp_valid;
    logic  rsp_ready = 1'b0;
    rsp_t  rsp_beat;

    // predictor state, a private copy of the sequencer
    phase_t     seq_phase = PH_IDLE;
    logic [7:0] smp_shift = '0;
    logic [7:0] img_in    = '0;
    logic [7:0] img_out   = '0;
    logic [7:0] img_snap  = '0;

    // expected response beats, oldest first
    rsp_t exp_pins_q[$];

    // handshake pacing, in percent of cycles spent idle
    int sender_gap_pct = 0;
    int sink_stall_pct = 0;

    // hold-off request to the sink process; hold_seq bumps to trigger it
    int hold_len  = 0;
    int hold_seq  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int beats_sent        = 0;
    int rsp_checked       = 0;
    int mismatch_count    = 0;
    int refreshes_started = 0;
    int quiet_cycles      = 0;

    shift_register_io_refresh_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_beat)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // phase predictor: executes one pin phase and returns the pin levels
    // ------------------------------------------------------------------------
    function automatic rsp_t predict_pin_phase(input req_t item);
        rsp_t       pins;
        phase_t     p;
        logic [5:0] off;
        logic [2:0] idx;
        pins = '0;
        pins.load_n = 1'b1;

        // an out-of-range phase behaves as idle
        if (seq_phase > PH_LAST)
            seq_phase = PH_IDLE;

        // host writes land before the phase action, even mid-refresh
        case (item.cmd)
            CMD_WRITE: img_out = item.out_byte;
            CMD_MASK:  img_out = item.bit_value ? (img_out | item.out_mask)
                                                : (img_out & ~item.out_mask);
            default: ;
        endcase

        // start from idle executes the first load phase in the same beat;
        // a start while busy is simply dropped
        if (seq_phase == PH_IDLE && item.cmd == CMD_START)
        begin
            seq_phase = PH_LOAD_FIRST;
            refreshes_started++;
        end

        p = seq_phase;
        if (p != PH_IDLE)
        begin
            pins.busy_res = 1'b1;
            if (p <= PH_LOAD_LAST)
            begin
                pins.load_n = 1'b0;
                pins.in_clk = (p == PH_LOAD_CLK);
            end
            else if (p <= PH_IN_LAST)
            begin
                // even offset samples di (stored inverted), odd offset clocks
                off = p - PH_IN_FIRST;
                idx = off[3:1];
                if (!off[0])
                    smp_shift[idx] = ~item.di;
                else
                    pins.in_clk = 1'b1;
            end
            else if (p == PH_COMPARE)
            begin
                if (smp_shift != img_in)
                begin
                    img_in = smp_shift;
                    pins.inputs_changed = 1'b1;
                end
                img_snap = img_out;
            end
            else if (p <= PH_OUT_LAST)
            begin
                // msb first, each bit held over a low and a high clock phase
                off = p - PH_OUT_FIRST;
                idx = 3'd7 - off[3:1];
                pins.out_data = img_snap[idx];
                pins.out_clk  = off[0];
            end
            else if (p == PH_OUT_HOLD)
            begin
                pins.out_data = img_snap[0];
            end
            else if (p == PH_LATCH)
            begin
                pins.out_data = img_snap[0];
                pins.latch    = 1'b1;
            end
            seq_phase = (p >= PH_LAST) ? PH_IDLE : p + phase_t'(1);
        end

        pins.input_byte = img_in;
        return pins;
    endfunction

    function automatic string pins_str(input rsp_t v);
        return $sformatf({"load_n=%b in_clk=%b out_clk=%b out_data=%b latch=%b ",
                          "input_byte=%h changed=%b busy=%b"},
                         v.load_n, v.in_clk, v.out_clk, v.out_data, v.latch,
                         v.input_byte, v.inputs_changed, v.busy_res);
    endfunction

    function automatic req_t make_beat(input cmd_t c);
        req_t b;
        b.cmd       = c;
        b.di        = 1'($urandom_range(1));
        b.out_byte  = 8'($urandom);
        b.out_mask  = 8'($urandom);
        b.bit_value = 1'($urandom_range(1));
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // request driver: one beat, random gaps before it, predicted on accept
    // ------------------------------------------------------------------------
    task automatic drive_request(input req_t item);
        @(negedge clk);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_beat  <= item;
        do
            @(posedge clk);
        while (!req_ready);
        exp_pins_q.push_back(predict_pin_phase(item));
        beats_sent++;
    endtask

    task automatic send_fields(input cmd_t c, input logic di, input logic [7:0] ob,
                               input logic [7:0] om, input logic bv);
        req_t b;
        b.cmd       = c;
        b.di        = di;
        b.out_byte  = ob;
        b.out_mask  = om;
        b.bit_value = bv;
        drive_request(b);
    endtask

    // one well-formed refresh: start, then random host traffic until idle,
    // with di steered so the sampled byte hits a chosen target
    task automatic run_one_refresh();
        logic [7:0] target;
        req_t       item;
        int         r;
        logic [5:0] off;
        // keep the image unchanged now and then so the no-change path is hit
        target = ($urandom_range(99) < 35) ? img_in : 8'($urandom);
        drive_request(make_beat(CMD_START));
        while (seq_phase != PH_IDLE)
        begin
            r = $urandom_range(99);
            if (r < 80)
                item = make_beat(CMD_NONE);
            else if (r < 88)
                item = make_beat(CMD_WRITE);
            else if (r < 96)
                item = make_beat(CMD_MASK);
            else
                item = make_beat(CMD_START);
            if (seq_phase >= PH_IN_FIRST && seq_phase <= PH_IN_LAST)
            begin
                off = seq_phase - PH_IN_FIRST;
                if (!off[0])
                    item.di = ~target[off[3:1]];
            end
            drive_request(item);
        end
    endtask

    task automatic run_noise(input int n);
        repeat (n)
            drive_request(make_beat(cmd_t'($urandom_range(3))));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_commands();
        logic [7:0] pattern;
        pattern = 8'b0110_1001;
        sender_gap_pct = 0;
        sink_stall_pct = 0;
        // idle beat with every other field at its top value
        send_fields(CMD_NONE,  1'b1, 8'hFF, 8'hFF, 1'b1);
        send_fields(CMD_WRITE, 1'b0, 8'hFF, 8'h00, 1'b0);
        send_fields(CMD_MASK,  1'b0, 8'h00, 8'hFF, 1'b0);
        send_fields(CMD_MASK,  1'b1, 8'hFF, 8'h00, 1'b1);
        send_fields(CMD_MASK,  1'b0, 8'h00, 8'hA5, 1'b1);
        send_fields(CMD_MASK,  1'b1, 8'h7E, 8'h81, 1'b0);
        // start from idle, then a second start while busy
        send_fields(CMD_START, 1'b0, 8'h00, 8'h00, 1'b0);
        send_fields(CMD_START, 1'b1, 8'h5A, 8'h5A, 1'b1);
        // writes while busy, before the snapshot
        send_fields(CMD_WRITE, 1'b1, 8'hC3, 8'h00, 1'b0);
        for (int k = 0; k < 16; k++)
        begin
            if (k == 5)
                send_fields(CMD_MASK, pattern[k >> 1], 8'h00, 8'h18, 1'b1);
            else if (k[0])
                send_fields(CMD_NONE, 1'($urandom_range(1)), 8'hFF, 8'hFF, 1'b0);
            else
                send_fields(CMD_NONE, pattern[k >> 1], 8'h00, 8'h00, 1'b0);
        end
    endtask

    task automatic test_refresh_traffic(input int n_items, input int gap_pct,
                                        input int stall_pct);
        int first;
        sender_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        first = beats_sent;
        while (beats_sent - first < n_items)
        begin
            if ($urandom_range(99) < 85)
                run_one_refresh();
            else
                run_noise($urandom_range(1, 8));
        end
    endtask

    // sink holds off for a long stretch while requests keep coming, so the
    // block fills and drops req_ready
    task automatic test_backpressure_fill();
        sender_gap_pct = 0;
        sink_stall_pct = 0;
        hold_len = HOLD_OFF_LEN;
        hold_seq++;
        run_one_refresh();
        run_one_refresh();
    endtask

    // ------------------------------------------------------------------------
    // response sink: random stalls, plus the long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // response checker: every accepted beat against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (exp_pins_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected response beat: %s", pins_str(rsp_beat));
            end
            else
            begin
                want = exp_pins_q.pop_front();
                if (rsp_beat !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("mismatch at response %0d", rsp_checked);
                        $display("  expected %s", pins_str(want));
                        $display("  actual   %s", pins_str(rsp_beat));
                    end
                end
            end
            rsp_checked++;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d responses outstanding",
                     quiet_cycles, exp_pins_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_commands();
        test_refresh_traffic(560, 23, 57);
        test_refresh_traffic(560, 57, 23);
        test_refresh_traffic(180, 0, 0);
        test_backpressure_fill();

        @(negedge clk);
        req_valid <= 1'b0;
        while (exp_pins_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d request beats, %0d refresh starts, %0d responses checked",
                 beats_sent, refreshes_started, rsp_checked);
        $display("pacing: 23/57 and 57/23 idle mixes, no idling, and a %0d-cycle sink hold-off",
                 HOLD_OFF_LEN);
        if (mismatch_count == 0 && exp_pins_q.size() == 0)
            $display("SUCCESS");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
